// ===== hdl/bia_pkg.sv =====
// bia_pkg: operator codes, widths and stage payload type for the integer ALU.
// No dependencies.
package bia_pkg;
    localparam int DataWidth = 32;
    localparam int NumStages = DataWidth;

    localparam logic [5:0] OP_ADD = 6'd0;
    localparam logic [5:0] OP_SUB = 6'd1;
    localparam logic [5:0] OP_MUL = 6'd2;
    localparam logic [5:0] OP_DIV = 6'd3;
    localparam logic [5:0] OP_MOD = 6'd4;
    localparam logic [5:0] OP_AND = 6'd5;
    localparam logic [5:0] OP_OR  = 6'd6;
    localparam logic [5:0] OP_XOR = 6'd7;
    localparam logic [5:0] OP_SHL = 6'd8;
    localparam logic [5:0] OP_SAR = 6'd9;
    localparam logic [5:0] ALIAS_LOW = 6'd20;
    localparam logic [5:0] ALIAS_HIGH = 6'd29;
    localparam logic [5:0] OP_EQ = 6'd40;
    localparam logic [5:0] OP_NE = 6'd41;
    localparam logic [5:0] OP_LE = 6'd42;
    localparam logic [5:0] OP_LT = 6'd43;
    localparam logic [5:0] OP_GE = 6'd44;
    localparam logic [5:0] OP_GT = 6'd45;
    localparam logic [5:0] OP_LAND = 6'd60;
    localparam logic [5:0] OP_LOR = 6'd61;

    typedef struct packed {
        logic        is_div;
        logic        want_rem;
        logic        neg_q;
        logic        neg_r;
        logic [31:0] left_raw;
        logic [31:0] divisor;
        logic [31:0] dividend;
        logic [31:0] quot;
        logic [31:0] rem;
        logic [31:0] result;
        logic        bad;
    } bia_word_t;
endpackage

// ===== hdl/bytecode_integer_alu_unit.sv =====
// Top level of the integer ALU: front decode, a chain of 32 cells (one
// division step each) and the output fix-up. Depends on bia_pkg.
//
//   channel | valid     | stall     | payload
//   in      | in_valid  | in_stall  | func, left_value, right_value
//   out     | out_valid | out_stall | result_value, bad_operator
//
// Every operation passes through all 32 cells, each a pipeline register, from
// input transfer to result; one item enters per cycle unless the output stalls.
// A stall on the output freezes the whole chain; in_stall follows out_stall
// only when the last cell holds a result. Reset empties the chain.
module bytecode_integer_alu_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [5:0]  func,
    input  logic signed [31:0] left_value,
    input  logic signed [31:0] right_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] result_value,
    output logic        bad_operator
);
    import bia_pkg::*;

    logic      advance;
    logic      v [NumStages+1];
    bia_word_t w [NumStages+1];
    bia_word_t last;
    logic [31:0] q_fix;
    logic [31:0] r_fix;

    assign advance = !(v[NumStages] && out_stall);
    assign in_stall = !advance;
    assign v[0] = in_valid;

    bia_front u_front (
        .func        (func),
        .left_value  (left_value),
        .right_value (right_value),
        .word        (w[0])
    );

    for (genvar i = 0; i < NumStages; i++)
    begin : g_chain
        bia_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (v[i]),
            .word_in   (w[i]),
            .valid_out (v[i+1]),
            .word_out  (w[i+1])
        );
    end

    always_comb
    begin
        last = w[NumStages];
        q_fix = last.neg_q ? (32'd0 - last.quot) : last.quot;
        r_fix = last.neg_r ? (32'd0 - last.rem) : last.rem;
        result_value = last.result;
        if (last.is_div)
        begin
            if (last.divisor == 32'd0)
                result_value = last.left_raw;
            else if (last.want_rem)
                result_value = r_fix;
            else
                result_value = q_fix;
        end
    end

    assign out_valid = v[NumStages];
    assign bad_operator = last.bad;
endmodule

// ===== hdl/bia_cell.sv =====
// bia_cell: one restoring-division step plus a pipeline register.
// Depends on bia_pkg.
module bia_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              valid_in,
    input  bia_pkg::bia_word_t word_in,
    output logic              valid_out,
    output bia_pkg::bia_word_t word_out
);
    import bia_pkg::*;

    logic        valid_reg;
    bia_word_t   word_reg;
    bia_word_t   word_next;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_comb
    begin
        word_next = word_in;
        shifted = {word_in.rem, word_in.dividend[31]};
        trial = shifted - {1'b0, word_in.divisor};
        if (word_in.is_div)
        begin
            word_next.dividend = {word_in.dividend[30:0], 1'b0};
            if (!trial[32])
            begin
                word_next.rem = trial[31:0];
                word_next.quot = {word_in.quot[30:0], 1'b1};
            end
            else
            begin
                word_next.rem = shifted[31:0];
                word_next.quot = {word_in.quot[30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            word_reg <= word_next;
    end

    assign valid_out = valid_reg;
    assign word_out = word_reg;
endmodule

// ===== hdl/bia_front.sv =====
// bia_front: decodes the operator, computes all non-division results and the
// multiply product, and sets up division operands. Depends on bia_pkg.
module bia_front (
    input  logic [5:0]  func,
    input  logic [31:0] left_value,
    input  logic [31:0] right_value,
    output bia_pkg::bia_word_t word
);
    import bia_pkg::*;

    logic [5:0]  f;
    logic [31:0] a;
    logic [31:0] b;
    logic        lt;
    logic        eq;
    logic [63:0] prod;

    always_comb
    begin
        a = left_value;
        b = right_value;
        f = func;
        if (func >= ALIAS_LOW && func <= ALIAS_HIGH)
            f = func - ALIAS_LOW;
        lt = $signed(a) < $signed(b);
        eq = a == b;
        prod = a * b;
        word = '0;
        word.left_raw = a;
        word.divisor = b[31] ? (32'd0 - b) : b;
        word.dividend = a[31] ? (32'd0 - a) : a;
        word.neg_r = a[31];
        word.neg_q = a[31] ^ b[31];
        unique case (f)
            OP_ADD: word.result = a + b;
            OP_SUB: word.result = a - b;
            OP_MUL: word.result = prod[31:0];
            OP_DIV:
            begin
                word.is_div = 1'b1;
            end
            OP_MOD:
            begin
                word.is_div = 1'b1;
                word.want_rem = 1'b1;
            end
            OP_AND: word.result = a & b;
            OP_OR:  word.result = a | b;
            OP_XOR: word.result = a ^ b;
            OP_SHL: word.result = a << b[4:0];
            OP_SAR: word.result = $unsigned($signed(a) >>> b[4:0]);
            OP_EQ:  word.result = {31'd0, eq};
            OP_NE:  word.result = {31'd0, !eq};
            OP_LE:  word.result = {31'd0, lt || eq};
            OP_LT:  word.result = {31'd0, lt};
            OP_GE:  word.result = {31'd0, !lt};
            OP_GT:  word.result = {31'd0, !lt && !eq};
            OP_LAND: word.result = {31'd0, (a != 32'd0) && (b != 32'd0)};
            OP_LOR:  word.result = {31'd0, (a != 32'd0) || (b != 32'd0)};
            default: word.bad = 1'b1;
        endcase
    end
endmodule

// ===== hdl/bia_checker.sv =====
// bia_checker: port-level assertions for bytecode_integer_alu_unit, and bind.
// Depends on nothing but the top-level ports.
module bia_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] result_value,
    input logic        bad_operator
);
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped under stall");
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(result_value) && $stable(bad_operator))
        else $error("stalled result changed");
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_operator |-> result_value == 32'd0)
        else $error("bad operator with nonzero result");
    a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");
endmodule

bind bytecode_integer_alu_unit bia_checker u_bia_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .bad_operator (bad_operator)
);
